// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== design/soc_pkg.sv =====
// ----------------------------------------------------------------------------
// soc_pkg
// Types, fixed-point constants and coefficient tables of the observer/controller.
// ----------------------------------------------------------------------------
package soc_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int STATE_COUNT = 4;
  localparam int MEAS_COUNT  = 2;
  localparam int TERM_COUNT  = STATE_COUNT + MEAS_COUNT;
  localparam int COEF_W      = FRAC_BITS + 8;
  localparam int PROD_W      = COEF_W + DATA_W;
  localparam int ACC_W       = PROD_W - FRAC_BITS + 3;
  localparam int STATE_IDX_W = $clog2(STATE_COUNT);
  localparam int LANE_CNT_W  = $clog2(TERM_COUNT + 1);
  localparam int MERGE_CNT_W = $clog2(STATE_COUNT + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    data_t meas_first;
    data_t meas_second;
  } meas_word_t;

  typedef struct packed {
    data_t command;
    data_t est_zero;
    data_t est_one;
    data_t est_two;
    data_t est_three;
  } result_word_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } merge_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SAT,
    ST_MERGE,
    ST_HOLD
  } state_t;

  // round(n / 10000 * 2^FRAC_BITS), ties away from zero
  function automatic coef_t cq(input longint n);
    longint one;
    longint mag;
    one = longint'(1) << FRAC_BITS;
    if (n >= 0) begin
      mag = (n * one + 5000) / 10000;
      return COEF_W'(mag);
    end
    mag = ((-n) * one + 5000) / 10000;
    return COEF_W'(-mag);
  endfunction

  localparam longint DEC_AB [STATE_COUNT][TERM_COUNT] = '{
    '{  6300,   -1206,    -8,    86,  3658,  1200 },
    '{  -953,    6935,   107,    12,  9930,  3070 },
    '{ -2896,  -19184, 11306,  2351, 10887, 20141 },
    '{ -39680, -17733, -1546,  7222, 31377, 16599 }
  };

  localparam longint DEC_C [STATE_COUNT] = '{ 803092, -96237, -141215, 236260 };

  function automatic coef_t coef_ab(input int k, input int j);
    return cq(DEC_AB[k][j]);
  endfunction

  function automatic coef_t coef_c(input int k);
    return cq(DEC_C[k]);
  endfunction

  localparam acc_t SAT_HI = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam acc_t SAT_LO = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  function automatic data_t sat_data(input acc_t v);
    if (v > SAT_HI) return SAT_HI[DATA_W-1:0];
    if (v < SAT_LO) return SAT_LO[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  // floor(product / 2^FRAC_BITS), widened to the accumulator
  function automatic acc_t scale_prod(input prod_t p);
    return ACC_W'($signed(p[PROD_W-1:FRAC_BITS]));
  endfunction

endpackage

// ===== design/state_observer_controller_unit.sv =====
// ----------------------------------------------------------------------------
// state_observer_controller_unit
// Four-state observer x' = A x + B y with command u = C x', signed fixed point.
// ----------------------------------------------------------------------------
// A new word is taken only in idle, once the last one has passed the six-term
//   MAC in each of the four row lanes, the four-step merge MAC and the hold state.
// A finished result waits in the output register; a new word is taken meanwhile.
// Reset (rst, synchronous): estimates cleared to zero, controller idle,
//   no result pending.
`include "assert_macros.svh"

module state_observer_controller_unit import soc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         meas_valid,
  output logic         meas_ready,
  input  meas_word_t   meas,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  state_t                state;
  state_t                state_next;
  logic [LANE_CNT_W-1:0] cnt;
  logic [LANE_CNT_W-1:0] cnt_next;
  meas_word_t            meas_hold;
  data_t                 x [STATE_COUNT];
  data_t                 lane_est [STATE_COUNT];
  coef_t                 lane_coef [STATE_COUNT];
  data_t                 operand;
  lane_ctrl_t            lctrl;
  merge_stat_t           mstat;
  data_t                 command;
  logic                  merge_start;
  logic                  load_x;
  logic                  load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    meas_ready   = 1'b0;
    lctrl.clr    = 1'b0;
    lctrl.mul_en = 1'b0;
    merge_start  = 1'b0;
    load_x       = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        meas_ready = 1'b1;
        if (meas_valid) begin
          lctrl.clr  = 1'b1;
          cnt_next   = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        lctrl.mul_en = cnt < LANE_CNT_W'(TERM_COUNT);
        if (cnt == LANE_CNT_W'(TERM_COUNT)) begin
          state_next = ST_SAT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SAT: begin
        load_x      = 1'b1;
        merge_start = 1'b1;
        state_next  = ST_MERGE;
      end
      ST_MERGE: begin
        if (mstat.done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cnt < LANE_CNT_W'(STATE_COUNT)) begin
      operand = x[cnt[STATE_IDX_W-1:0]];
    end else if (cnt == LANE_CNT_W'(STATE_COUNT)) begin
      operand = meas_hold.meas_first;
    end else begin
      operand = meas_hold.meas_second;
    end
  end

  always_comb begin
    for (int k = 0; k < STATE_COUNT; k++) begin
      lane_coef[k] = '0;
      for (int j = 0; j < TERM_COUNT; j++) begin
        if (cnt == LANE_CNT_W'(j)) lane_coef[k] = coef_ab(k, j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && meas_ready) meas_hold <= meas;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STATE_COUNT; k++) x[k] <= '0;
    end else if (load_x) begin
      for (int k = 0; k < STATE_COUNT; k++) x[k] <= lane_est[k];
    end
  end

  for (genvar k = 0; k < STATE_COUNT; k++) begin : g_lane
    soc_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lctrl),
      .coef    (lane_coef[k]),
      .operand (operand),
      .est     (lane_est[k])
    );
  end

  soc_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .start   (merge_start),
    .est     (x),
    .stat    (mstat),
    .command (command)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.command   <= command;
      result.est_zero  <= x[0];
      result.est_one   <= x[1];
      result.est_two   <= x[2];
      result.est_three <= x[3];
    end
  end

  `ASSERT_NEXT(a_accept_starts_mac, clk, rst, meas_valid && meas_ready, state == ST_MAC && cnt == '0, "accepted word did not start the lane MAC")
  `ASSERT_IMPL(a_merge_start_idle, clk, rst, merge_start, !mstat.busy, "merge started while busy")
  `ASSERT_IMPL(a_result_from_hold, clk, rst, $rose(result_valid), $past(state) == ST_HOLD, "result raised outside hold")

endmodule

// ===== design/soc_lane.sv =====
// ----------------------------------------------------------------------------
// soc_lane
// One state row: multiply-accumulate over A row and B row, saturated result.
// ----------------------------------------------------------------------------
module soc_lane import soc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  coef_t      coef,
  input  data_t      operand,
  output data_t      est
);

  prod_t prod;
  logic  prod_valid;
  acc_t  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.mul_en && !ctrl.clr;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * operand;
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + scale_prod(prod);
    end
  end

  assign est = sat_data(acc);

endmodule

// ===== design/soc_merge.sv =====
// ----------------------------------------------------------------------------
// soc_merge
// Combines lane estimates into the command u = C x' on one shared MAC.
// ----------------------------------------------------------------------------
module soc_merge import soc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  data_t       est [STATE_COUNT],
  output merge_stat_t stat,
  output data_t       command
);

  logic [MERGE_CNT_W-1:0] cnt;
  logic                   busy;
  logic                   done;
  logic                   prod_valid;
  prod_t                  prod;
  acc_t                   acc;
  coef_t                  coef;

  always_comb begin
    coef = '0;
    for (int i = 0; i < STATE_COUNT; i++) begin
      if (cnt[STATE_IDX_W-1:0] == STATE_IDX_W'(i)) coef = coef_c(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      prod_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      done       <= 1'b0;
      prod_valid <= busy && (cnt < MERGE_CNT_W'(STATE_COUNT));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == MERGE_CNT_W'(STATE_COUNT)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * est[cnt[STATE_IDX_W-1:0]];
    if (start) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + scale_prod(prod);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign command   = sat_data(acc);

endmodule

// ===== dv/tb_state_observer_controller_unit.sv =====
// ----------------------------------------------------------------------------
// tb_state_observer_controller_unit
// Drives measurement words into the four-state observer/controller and checks
// every result word, field by field, against an in-bench fixed-point model of
// x' = A x + B y and u = C x' (floor-truncated products, 32-bit saturation).
// Covers small, large and extreme samples, estimate and command saturation,
// random idling on both channels, an output hold-off that stalls the input,
// and a full drain between bursts.
// ----------------------------------------------------------------------------
module tb_state_observer_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import soc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int WATCHDOG_CYCLES = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;

  // Gains in units of 1e-4; columns 0..3 are A, 4..5 are B.
  localparam longint ROW_GAIN_TENK [STATE_COUNT][TERM_COUNT] = '{
    '{   6300,  -1206,    -8,    86,  3658,  1200 },
    '{   -953,   6935,   107,    12,  9930,  3070 },
    '{  -2896, -19184, 11306,  2351, 10887, 20141 },
    '{ -39680, -17733, -1546,  7222, 31377, 16599 }
  };
  localparam longint CMD_GAIN_TENK [STATE_COUNT] = '{ 803092, -96237, -141215, 236260 };

  logic         clk;
  logic         rst          = 1'b1;
  logic         meas_valid   = 1'b0;
  logic         meas_ready;
  meas_word_t   meas         = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_word_t result;

  data_t        est_model [STATE_COUNT] = '{default: '0};
  result_word_t pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  tx_idle_pct    = 32;
  int unsigned  rx_idle_pct    = 32;
  int unsigned  rx_hold_left   = 0;

  state_observer_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .meas_valid   (meas_valid),
    .meas_ready   (meas_ready),
    .meas         (meas),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint to_q16(longint tenk);
    longint mag;
    mag = ((tenk < 0 ? -tenk : tenk) * (longint'(1) << (FRAC_BITS + 1)) + 10000) / 20000;
    return (tenk < 0) ? -mag : mag;
  endfunction

  // floor(gain * x / 2^FRAC_BITS)
  function automatic longint gain_mul(longint tenk, data_t x);
    return (to_q16(tenk) * longint'(x)) >>> FRAC_BITS;
  endfunction

  function automatic data_t sat_word(longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -longint'(32'sh7fff_ffff) - 1) return 32'sh8000_0000;
    return data_t'(v);
  endfunction

  function automatic result_word_t observer_update(meas_word_t m);
    data_t        nx [STATE_COUNT];
    longint       acc;
    result_word_t r;
    for (int k = 0; k < STATE_COUNT; k++) begin
      acc = 0;
      for (int j = 0; j < STATE_COUNT; j++)
        acc += gain_mul(ROW_GAIN_TENK[k][j], est_model[j]);
      acc += gain_mul(ROW_GAIN_TENK[k][STATE_COUNT], m.meas_first);
      acc += gain_mul(ROW_GAIN_TENK[k][STATE_COUNT + 1], m.meas_second);
      nx[k] = sat_word(acc);
    end
    acc = 0;
    for (int k = 0; k < STATE_COUNT; k++) begin
      est_model[k] = nx[k];
      acc += gain_mul(CMD_GAIN_TENK[k], nx[k]);
    end
    r.command   = sat_word(acc);
    r.est_zero  = nx[0];
    r.est_one   = nx[1];
    r.est_two   = nx[2];
    r.est_three = nx[3];
    return r;
  endfunction

  function automatic void check_field(string name, data_t want_v, data_t got_v);
    if (want_v !== got_v) begin
      $display("%0t %s: expected %h, actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  function automatic data_t rand_sample();
    case ($urandom_range(19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return data_t'($urandom);
      4, 5, 6: return data_t'(int'($urandom) >>> 5);
      default: return data_t'(int'($urandom) >>> 13);
    endcase
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      result_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result word with none expected: expected none, actual %h",
                 $time, result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("command",   want.command,   result.command);
        check_field("est_zero",  want.est_zero,  result.est_zero);
        check_field("est_one",   want.est_one,   result.est_one);
        check_field("est_two",   want.est_two,   result.est_two);
        check_field("est_three", want.est_three, result.est_three);
      end
    end
  end

  task automatic send_meas(input data_t first, input data_t second);
    meas_word_t w;
    w.meas_first  = first;
    w.meas_second = second;
    while ($urandom_range(99) < tx_idle_pct) begin
      meas_valid <= 1'b0;
      @(posedge clk);
    end
    meas_valid <= 1'b1;
    meas       <= w;
    do @(posedge clk); while (!meas_ready);
    pending_results.push_back(observer_update(w));
  endtask

  task automatic wait_all_results();
    meas_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_small_values();
    send_meas(32'sd0, 32'sd0);
    send_meas(32'sd1, -32'sd1);
    send_meas(-32'sd1, -32'sd1);
    send_meas(32'sh0001_0000, 32'sd0);
    send_meas(32'sd0, 32'sh0001_0000);
    send_meas(-32'sh0001_0000, 32'sd0);
    send_meas(32'sd0, -32'sh0001_0000);
    send_meas(32'sd3, -32'sd7);
  endtask

  task automatic test_saturation();
    send_meas(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_meas(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_meas(32'sh8000_0000, 32'sh8000_0000);
    send_meas(32'sh8000_0000, 32'sh8000_0000);
    send_meas(32'sh7fff_ffff, 32'sh8000_0000);
    send_meas(32'sh8000_0000, 32'sh7fff_ffff);
    send_meas(32'sh5555_5555, 32'shaaaa_aaaa);
    send_meas(32'shaaaa_aaaa, 32'sh5555_5555);
  endtask

  task automatic test_decay();
    repeat (5) send_meas(32'sd0, 32'sd0);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_meas(rand_sample(), rand_sample());
  endtask

  task automatic test_full_rate(input int unsigned count);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(count);
    tx_idle_pct = 32;
    rx_idle_pct = 32;
  endtask

  task automatic test_output_hold_off();
    meas_valid <= 1'b0;
    @(negedge clk);
    rx_hold_left = HOLD_OFF_CYCLES;
    @(posedge clk);
    tx_idle_pct = 0;
    test_random(12);
    tx_idle_pct = 32;
    while (rx_hold_left != 0) @(posedge clk);
  endtask

  task automatic test_drain_pause();
    wait_all_results();
    test_random(80);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_small_values();
    test_saturation();
    test_decay();
    test_random(1300);
    test_full_rate(300);
    test_output_hold_off();
    test_drain_pause();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
